/* design/chd_pkg.sv */
// Shared types and constants for the chunked body decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package chd_pkg;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [1:0] TRAILER_LEN = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic       chunk_last;
	} chd_result_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t h;
		h.is_hex = 1'b1;
		h.value  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.value = c[3:0] + 4'd9;
		end else begin
			h.is_hex = 1'b0;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

/* design/chd_parser.sv */
// Parser core: phase, size and count registers plus the per-byte step logic.
// Depends on chd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chd_parser #(
	parameter int SIZE_DIGITS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  fire,
	input  wire [7:0]            body_byte,
	input  wire                  body_start,
	output logic                 res_valid,
	output chd_pkg::chd_result_t res
);
	import chd_pkg::*;

	localparam int DC_W = $clog2(SIZE_DIGITS + 2);

	localparam logic [2:0] PH_SIZE = 3'd0;
	localparam logic [2:0] PH_DATA = 3'd1;
	localparam logic [2:0] PH_SKIP = 3'd2;
	localparam logic [2:0] PH_DONE = 3'd3;
	localparam logic [2:0] PH_HALT = 3'd4;

	logic [2:0]      phase_q, phase_d, phase_c;
	logic [31:0]     acc_q, acc_d, acc_c;
	logic [31:0]     rem_q, rem_d, rem_c;
	logic [DC_W-1:0] dc_q, dc_d, dc_c;
	logic            closed_q, closed_d, closed_c;
	logic            cr_q, cr_d, cr_c;
	logic [1:0]      skip_q, skip_d, skip_c;
	hex_digit_t      hd;
	logic            last;

	always_comb begin
		// a body start clears everything before the byte is parsed
		phase_c  = body_start ? PH_SIZE : phase_q;
		acc_c    = body_start ? 32'd0 : acc_q;
		rem_c    = body_start ? 32'd0 : rem_q;
		dc_c     = body_start ? '0 : dc_q;
		closed_c = body_start ? 1'b0 : closed_q;
		cr_c     = body_start ? 1'b0 : cr_q;
		skip_c   = body_start ? 2'd0 : skip_q;

		phase_d  = phase_c;
		acc_d    = acc_c;
		rem_d    = rem_c;
		dc_d     = dc_c;
		closed_d = closed_c;
		cr_d     = cr_c;
		skip_d   = skip_c;

		hd        = hex_decode(body_byte);
		last      = (rem_c <= 32'd1);
		res_valid = 1'b0;
		res       = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, chunk_last: 1'b0};

		unique case (phase_c)
			PH_SIZE: begin
				if (cr_c && body_byte == CHAR_LF) begin
					acc_d     = 32'd0;
					dc_d      = '0;
					closed_d  = 1'b0;
					cr_d      = 1'b0;
					if (dc_c == '0 || dc_c > DC_W'(SIZE_DIGITS)) begin
						phase_d   = PH_HALT;
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
					end else if (acc_c == 32'd0) begin
						phase_d   = PH_DONE;
						res_valid = 1'b1;
						res.kind  = KIND_END;
					end else begin
						rem_d   = acc_c;
						phase_d = PH_DATA;
					end
				end else begin
					cr_d = (body_byte == CHAR_CR);
					if (!hd.is_hex) begin
						closed_d = 1'b1;
					end else if (!closed_c) begin
						acc_d = {acc_c[27:0], hd.value};
						if (dc_c <= DC_W'(SIZE_DIGITS)) begin
							dc_d = dc_c + 1'b1;
						end
					end
				end
			end
			PH_DATA: begin
				rem_d = (rem_c != 32'd0) ? rem_c - 32'd1 : 32'd0;
				if (last) begin
					rem_d   = 32'd0;
					phase_d = PH_SKIP;
					skip_d  = TRAILER_LEN;
				end
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = body_byte;
				res.chunk_last   = last;
			end
			PH_SKIP: begin
				skip_d = (skip_c != 2'd0) ? skip_c - 2'd1 : 2'd0;
				if (skip_d == 2'd0) begin
					phase_d  = PH_SIZE;
					acc_d    = 32'd0;
					dc_d     = '0;
					closed_d = 1'b0;
					cr_d     = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIZE;
			acc_q    <= 32'd0;
			rem_q    <= 32'd0;
			dc_q     <= '0;
			closed_q <= 1'b0;
			cr_q     <= 1'b0;
			skip_q   <= 2'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			rem_q    <= rem_d;
			dc_q     <= dc_d;
			closed_q <= closed_d;
			cr_q     <= cr_d;
			skip_q   <= skip_d;
		end
	end

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != 32'd0)
		else $error("payload phase with no bytes left");

	a_skip_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != 2'd0)
		else $error("trailer phase with zero skip count");

	a_digit_sat: assert property (@(posedge clk) disable iff (!arst_n)
		dc_q <= DC_W'(SIZE_DIGITS + 1))
		else $error("digit count beyond saturation");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && res.kind == KIND_ERROR |=> phase_q == PH_HALT)
		else $error("error result without halt");

endmodule

`default_nettype wire

/* design/chd_out_reg.sv */
// Result register with valid/ready toward the receiver.
// Depends on chd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chd_out_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  chd_pkg::chd_result_t din,
	output logic                 free,
	output logic                 result_valid,
	input  wire                  result_ready,
	output chd_pkg::chd_result_t dout
);
	import chd_pkg::*;

	logic        valid_q;
	chd_result_t data_q;

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign dout         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= din;
		end
	end

endmodule

`default_nettype wire

/* design/http_chunked_body_decoder_unit.sv */
// HTTP/1.1 chunked transfer decoder: top level with the input stage register.
// Depends on chd_pkg, chd_parser and chd_out_reg.
//
// Usage:
//   Body channel: body_valid/body_ready carry one raw body byte per beat,
//   with body_start set on the first byte of a new body (parser restarts).
//   Result channel: result_valid/result_ready carry kind, payload_byte and
//   chunk_last. A beat yields at most one result: a payload byte (kind 0),
//   the terminal chunk (kind 1) or a size line error (kind 2). Size lines,
//   CR LF and chunk trailers produce nothing.
//   Path: the accepting edge writes the byte to the input stage register,
//   and the result register takes the parser result once it is free.
//   Throughput: one byte per cycle while results are taken, set by the
//   combinational parser step between the two registers.
//   Reset: arst_n clears both stages and the parser to the start of a size
//   line. When the receiver stalls, the result register holds, the input
//   stage fills, and body_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder_unit #(
	parameter int SIZE_DIGITS = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        body_valid,
	output logic       body_ready,
	input  wire [7:0]  body_byte,
	input  wire        body_start,
	output logic       result_valid,
	input  wire        result_ready,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic       chunk_last
);
	import chd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        out_free;
	logic        fire;
	logic        res_valid;
	chd_result_t res;
	chd_result_t dout;

	assign fire       = valid_s1 && out_free;
	assign body_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body_ready) begin
			valid_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body_ready && body_valid) begin
			byte_s1  <= body_byte;
			start_s1 <= body_start;
		end
	end

	chd_parser #(
		.SIZE_DIGITS(SIZE_DIGITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.body_byte  (byte_s1),
		.body_start (start_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	chd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && res_valid),
		.din          (res),
		.free         (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.dout         (dout)
	);

	assign kind         = dout.kind;
	assign payload_byte = dout.payload_byte;
	assign chunk_last   = dout.chunk_last;

endmodule

`default_nettype wire
